@@ sv/indexed_linked_list_store_top_assert.svh @@
// assertion macros for the linked list store
// used by indexed_linked_list_store_top, needs aclk and aresetn in scope
`ifndef INDEXED_LINKED_LIST_STORE_TOP_ASSERT_SVH
`define INDEXED_LINKED_LIST_STORE_TOP_ASSERT_SVH

// same-cycle implication
`define ILLS_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define ILLS_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ sv/ills_pkg.sv @@
// shared constants and codes for the linked list store
// no dependencies
package ills_pkg;

    localparam int CAPACITY = 1024;
    localparam int ADDR_W   = $clog2(CAPACITY);
    localparam int LEN_W    = 11;
    localparam int VAL_W    = 32;
    localparam int CMD_W    = 3;
    localparam int ST_W     = 2;

    localparam logic [LEN_W-1:0] CAP_LEN = LEN_W'(CAPACITY);

    typedef enum logic [CMD_W-1:0] {
        CMD_READ     = 3'd0,
        CMD_INS_HEAD = 3'd1,
        CMD_INS_TAIL = 3'd2,
        CMD_INS_POS  = 3'd3,
        CMD_DELETE   = 3'd4
    } cmd_t;

    typedef enum logic [ST_W-1:0] {
        ST_DONE  = 2'd0,
        ST_RANGE = 2'd1,
        ST_FULL  = 2'd2
    } status_t;

endpackage

@@ sv/indexed_linked_list_store_top.sv @@
// Ordered list of signed 32-bit values in a linked store with a free chain.
// The walk from the head toward a command's position reads one link per cycle
// from the link memory. One command is worked at a time; s_tready is high only
// between commands, and a finished result waits in the output register while
// the next item is taken.
// Slot order is not visible at the ports: never-used slots are handed out by
// a high-water count, so no clearing pass runs after reset.
// Depends on ills_pkg and indexed_linked_list_store_top_assert.svh.
`include "indexed_linked_list_store_top_assert.svh"

module indexed_linked_list_store_top (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    // cmd [2:0], position [13:3], item_value [45:14], zero [47:46]
    input  logic [47:0] s_tdata,
    output logic        m_tvalid,
    input  logic        m_tready,
    // read_value [31:0], status [33:32], list_length [44:34], zero [47:45]
    output logic [47:0] m_tdata
);

    localparam int AW = ills_pkg::ADDR_W;
    localparam int LW = ills_pkg::LEN_W;
    localparam int VW = ills_pkg::VAL_W;

    typedef enum logic [3:0] {
        S_IDLE, S_DECIDE, S_POP, S_WALK,
        S_VAL_ISSUE, S_VAL_WAIT,
        S_INS_HEAD, S_INS_PREV, S_INS_SUCC, S_INS_FIX,
        S_DEL_HEAD, S_DEL_PREV, S_DEL_VICT, S_DEL_NEXT, S_DEL_FREE,
        S_OUT
    } state_t;

    state_t state_reg, state_next, post_reg, post_next;

    logic [ills_pkg::CMD_W-1:0] cmd_reg, cmd_next;
    logic [LW-1:0] pos_reg, pos_next;
    logic [VW-1:0] val_reg, val_next;
    logic [AW-1:0] head_reg, head_next;
    logic [AW-1:0] free_head_reg, free_head_next;
    logic [LW-1:0] count_reg, count_next;
    logic [LW-1:0] fresh_reg, fresh_next;
    logic [AW-1:0] cur_reg, cur_next;
    logic [LW-1:0] steps_reg, steps_next;
    logic [AW-1:0] new_slot_reg, new_slot_next;
    logic [AW-1:0] tmp_reg, tmp_next;
    logic [VW-1:0] res_val_reg, res_val_next;
    logic [ills_pkg::ST_W-1:0] res_st_reg, res_st_next;
    logic          m_tvalid_reg, m_tvalid_next;
    logic [47:0]   m_tdata_reg, m_tdata_next;

    logic [AW-1:0] link_mem [ills_pkg::CAPACITY];
    logic [VW-1:0] value_mem [ills_pkg::CAPACITY];

    logic          link_we;
    logic [AW-1:0] link_waddr, link_wdata, link_raddr, link_q;
    logic          val_we;
    logic [AW-1:0] val_raddr;
    logic [VW-1:0] val_q;

    logic [LW-1:0] pos_m1;
    assign pos_m1 = pos_reg - LW'(1);

    always_ff @(posedge aclk) begin
        if (link_we) begin
            link_mem[link_waddr] <= link_wdata;
        end
        link_q <= link_mem[link_raddr];
    end

    always_ff @(posedge aclk) begin
        if (val_we) begin
            value_mem[new_slot_reg] <= val_reg;
        end
        val_q <= value_mem[val_raddr];
    end

    always_comb begin
        state_next     = state_reg;
        post_next      = post_reg;
        cmd_next       = cmd_reg;
        pos_next       = pos_reg;
        val_next       = val_reg;
        head_next      = head_reg;
        free_head_next = free_head_reg;
        count_next     = count_reg;
        fresh_next     = fresh_reg;
        cur_next       = cur_reg;
        steps_next     = steps_reg;
        new_slot_next  = new_slot_reg;
        tmp_next       = tmp_reg;
        res_val_next   = res_val_reg;
        res_st_next    = res_st_reg;
        m_tvalid_next  = m_tvalid_reg;
        m_tdata_next   = m_tdata_reg;
        link_we        = 1'b0;
        link_waddr     = cur_reg;
        link_wdata     = new_slot_reg;
        link_raddr     = cur_reg;
        val_we         = 1'b0;
        val_raddr      = cur_reg;

        if (m_tvalid_reg && m_tready) begin
            m_tvalid_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE: begin
                if (s_tvalid) begin
                    cmd_next = s_tdata[2:0];
                    val_next = s_tdata[45:14];
                    case (s_tdata[2:0])
                        ills_pkg::CMD_INS_HEAD: pos_next = '0;
                        ills_pkg::CMD_INS_TAIL: pos_next = count_reg;
                        default:                pos_next = s_tdata[13:3];
                    endcase
                    state_next = S_DECIDE;
                end
            end
            S_DECIDE: begin
                res_val_next = '0;
                res_st_next  = ills_pkg::ST_DONE;
                case (cmd_reg) inside
                    ills_pkg::CMD_READ: begin
                        if (pos_reg >= count_reg) begin
                            res_val_next = '1;
                            res_st_next  = ills_pkg::ST_RANGE;
                            state_next   = S_OUT;
                        end else begin
                            cur_next   = head_reg;
                            steps_next = pos_reg;
                            post_next  = S_VAL_ISSUE;
                            if (pos_reg == '0) begin
                                state_next = S_VAL_ISSUE;
                            end else begin
                                link_raddr = head_reg;
                                state_next = S_WALK;
                            end
                        end
                    end
                    ills_pkg::CMD_INS_HEAD, ills_pkg::CMD_INS_TAIL,
                    ills_pkg::CMD_INS_POS: begin
                        if (pos_reg > count_reg) begin
                            res_st_next = ills_pkg::ST_RANGE;
                            state_next  = S_OUT;
                        end else if (count_reg == ills_pkg::CAP_LEN) begin
                            res_st_next = ills_pkg::ST_FULL;
                            state_next  = S_OUT;
                        end else if (fresh_reg != count_reg) begin
                            // reuse a slot from the recycled chain
                            new_slot_next = free_head_reg;
                            link_raddr    = free_head_reg;
                            state_next    = S_POP;
                        end else begin
                            // never-used slot, its link is not needed
                            new_slot_next = fresh_reg[AW-1:0];
                            fresh_next    = fresh_reg + LW'(1);
                            cur_next      = head_reg;
                            steps_next    = pos_m1;
                            post_next     = S_INS_PREV;
                            if (pos_reg == '0) begin
                                state_next = S_INS_HEAD;
                            end else if (pos_m1 == '0) begin
                                state_next = S_INS_PREV;
                            end else begin
                                link_raddr = head_reg;
                                state_next = S_WALK;
                            end
                        end
                    end
                    ills_pkg::CMD_DELETE: begin
                        if (pos_reg >= count_reg) begin
                            res_st_next = ills_pkg::ST_RANGE;
                            state_next  = S_OUT;
                        end else if (pos_reg == '0) begin
                            tmp_next   = head_reg;
                            link_raddr = head_reg;
                            state_next = S_DEL_HEAD;
                        end else begin
                            cur_next   = head_reg;
                            steps_next = pos_m1;
                            post_next  = S_DEL_PREV;
                            if (pos_m1 == '0) begin
                                state_next = S_DEL_PREV;
                            end else begin
                                link_raddr = head_reg;
                                state_next = S_WALK;
                            end
                        end
                    end
                    default: begin
                        state_next = S_OUT;
                    end
                endcase
            end
            S_POP: begin
                free_head_next = link_q;
                cur_next       = head_reg;
                steps_next     = pos_m1;
                post_next      = S_INS_PREV;
                if (pos_reg == '0) begin
                    state_next = S_INS_HEAD;
                end else if (pos_m1 == '0) begin
                    state_next = S_INS_PREV;
                end else begin
                    link_raddr = head_reg;
                    state_next = S_WALK;
                end
            end
            S_WALK: begin
                // link_q holds the link of the slot read last cycle
                cur_next   = link_q;
                steps_next = steps_reg - LW'(1);
                if (steps_reg == LW'(1)) begin
                    state_next = post_reg;
                end else begin
                    link_raddr = link_q;
                end
            end
            S_VAL_ISSUE: begin
                val_raddr  = cur_reg;
                state_next = S_VAL_WAIT;
            end
            S_VAL_WAIT: begin
                res_val_next = val_q;
                state_next   = S_OUT;
            end
            S_INS_HEAD: begin
                link_we    = 1'b1;
                link_waddr = new_slot_reg;
                link_wdata = head_reg;
                val_we     = 1'b1;
                head_next  = new_slot_reg;
                count_next = count_reg + LW'(1);
                state_next = S_OUT;
            end
            S_INS_PREV: begin
                link_raddr = cur_reg;
                state_next = S_INS_SUCC;
            end
            S_INS_SUCC: begin
                link_we    = 1'b1;
                link_waddr = new_slot_reg;
                link_wdata = link_q;
                val_we     = 1'b1;
                state_next = S_INS_FIX;
            end
            S_INS_FIX: begin
                link_we    = 1'b1;
                link_waddr = cur_reg;
                link_wdata = new_slot_reg;
                count_next = count_reg + LW'(1);
                state_next = S_OUT;
            end
            S_DEL_HEAD: begin
                head_next      = link_q;
                link_we        = 1'b1;
                link_waddr     = tmp_reg;
                link_wdata     = free_head_reg;
                free_head_next = tmp_reg;
                count_next     = count_reg - LW'(1);
                state_next     = S_OUT;
            end
            S_DEL_PREV: begin
                link_raddr = cur_reg;
                state_next = S_DEL_VICT;
            end
            S_DEL_VICT: begin
                tmp_next   = link_q;
                link_raddr = link_q;
                state_next = S_DEL_NEXT;
            end
            S_DEL_NEXT: begin
                // bypass the victim
                link_we    = 1'b1;
                link_waddr = cur_reg;
                link_wdata = link_q;
                state_next = S_DEL_FREE;
            end
            S_DEL_FREE: begin
                link_we        = 1'b1;
                link_waddr     = tmp_reg;
                link_wdata     = free_head_reg;
                free_head_next = tmp_reg;
                count_next     = count_reg - LW'(1);
                state_next     = S_OUT;
            end
            S_OUT: begin
                if (!m_tvalid_reg || m_tready) begin
                    m_tvalid_next = 1'b1;
                    m_tdata_next  = {3'b000, count_reg, res_st_reg, res_val_reg};
                    state_next    = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_IDLE;
            m_tvalid_reg  <= 1'b0;
            head_reg      <= '0;
            free_head_reg <= '0;
            count_reg     <= '0;
            fresh_reg     <= '0;
        end else begin
            state_reg     <= state_next;
            m_tvalid_reg  <= m_tvalid_next;
            head_reg      <= head_next;
            free_head_reg <= free_head_next;
            count_reg     <= count_next;
            fresh_reg     <= fresh_next;
        end
        post_reg     <= post_next;
        cmd_reg      <= cmd_next;
        pos_reg      <= pos_next;
        val_reg      <= val_next;
        cur_reg      <= cur_next;
        steps_reg    <= steps_next;
        new_slot_reg <= new_slot_next;
        tmp_reg      <= tmp_next;
        res_val_reg  <= res_val_next;
        res_st_reg   <= res_st_next;
        m_tdata_reg  <= m_tdata_next;
    end

    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    `ILLS_ASSERT_NOW(a_count_cap, 1'b1, count_reg <= ills_pkg::CAP_LEN, "length above capacity")
    `ILLS_ASSERT_NOW(a_fresh_cover, 1'b1, fresh_reg >= count_reg, "high-water below length")
    `ILLS_ASSERT_NEXT(a_idle_hold, state_reg == S_IDLE, count_reg == $past(count_reg), "length moved while idle")
    `ILLS_ASSERT_NEXT(a_walk_len, state_reg == S_WALK, steps_reg < count_reg, "walk beyond list end")

endmodule

@@ tb/indexed_linked_list_store_top_tb.sv @@
// self-checking testbench for indexed_linked_list_store_top: stream commands in, compare
// results against a queue-based list model or a directed-row table; needs ills_pkg, top rtl
`timescale 1ns / 100ps

module indexed_linked_list_store_top_tb;

    localparam int CLK_PERIOD      = 20;
    localparam int MIX_ITEMS       = 200;
    localparam int FILL_ITEMS      = 150;
    localparam int PRESSURE_AT     = 400;
    localparam int PRESSURE_CYCLES = 300;
    localparam int WATCHDOG_LIMIT  = 5000;
    localparam int TAIL_CYCLES     = 40;

    typedef logic [ills_pkg::CMD_W-1:0] cmd_bits_t;
    typedef logic [ills_pkg::LEN_W-1:0] len_bits_t;
    typedef logic [ills_pkg::VAL_W-1:0] val_bits_t;

    localparam cmd_bits_t CMD_UNUSED_LO  = 3'd5;
    localparam cmd_bits_t CMD_UNUSED_MID = 3'd6;
    localparam cmd_bits_t CMD_UNUSED_HI  = 3'd7;
    localparam val_bits_t NO_ENTRY       = 32'hFFFF_FFFF;

    typedef struct packed {
        val_bits_t          read_value;
        ills_pkg::status_t  status;
        len_bits_t          list_length;
    } list_result_t;

    typedef struct packed {
        cmd_bits_t    cmd;
        len_bits_t    pos;
        val_bits_t    val;
        logic         typed;
        list_result_t res;
    } stim_row_t;

    typedef enum {PH_MIX, PH_FILL} phase_t;

    localparam list_result_t BY_MODEL = '{32'd0, ills_pkg::ST_DONE, 11'd0};

    localparam stim_row_t DIRECTED_ROWS [25] = '{
        '{ills_pkg::CMD_READ,     11'd0,    32'd0,         1'b1,
          '{NO_ENTRY, ills_pkg::ST_RANGE, 11'd0}},
        '{ills_pkg::CMD_DELETE,   11'd0,    32'd0,         1'b1,
          '{32'd0, ills_pkg::ST_RANGE, 11'd0}},
        '{ills_pkg::CMD_INS_POS,  11'd1,    32'd1,         1'b1,
          '{32'd0, ills_pkg::ST_RANGE, 11'd0}},
        '{ills_pkg::CMD_INS_TAIL, 11'd0,    32'h7FFF_FFFF, 1'b1,
          '{32'd0, ills_pkg::ST_DONE, 11'd1}},
        '{ills_pkg::CMD_INS_HEAD, 11'd2047, 32'h8000_0000, 1'b1,
          '{32'd0, ills_pkg::ST_DONE, 11'd2}},
        '{ills_pkg::CMD_INS_POS,  11'd2,    32'hFFFF_FFFF, 1'b1,
          '{32'd0, ills_pkg::ST_DONE, 11'd3}},
        '{ills_pkg::CMD_READ,     11'd0,    32'd0,         1'b1,
          '{32'h8000_0000, ills_pkg::ST_DONE, 11'd3}},
        '{ills_pkg::CMD_READ,     11'd2,    32'd0,         1'b1,
          '{32'hFFFF_FFFF, ills_pkg::ST_DONE, 11'd3}},
        '{ills_pkg::CMD_READ,     11'd3,    32'd0,         1'b1,
          '{NO_ENTRY, ills_pkg::ST_RANGE, 11'd3}},
        '{ills_pkg::CMD_READ,     11'd2047, 32'd0,         1'b1,
          '{NO_ENTRY, ills_pkg::ST_RANGE, 11'd3}},
        '{ills_pkg::CMD_INS_POS,  11'd4,    32'd5,         1'b1,
          '{32'd0, ills_pkg::ST_RANGE, 11'd3}},
        '{ills_pkg::CMD_INS_POS,  11'd0,    32'd0,         1'b0, BY_MODEL},
        '{ills_pkg::CMD_INS_POS,  11'd2,    32'h1234_5678, 1'b0, BY_MODEL},
        '{CMD_UNUSED_LO,          11'd0,    32'd0,         1'b1,
          '{32'd0, ills_pkg::ST_DONE, 11'd5}},
        '{CMD_UNUSED_MID,         11'd2047, 32'hFFFF_FFFF, 1'b1,
          '{32'd0, ills_pkg::ST_DONE, 11'd5}},
        '{CMD_UNUSED_HI,          11'd1024, 32'h5555_5555, 1'b1,
          '{32'd0, ills_pkg::ST_DONE, 11'd5}},
        '{ills_pkg::CMD_READ,     11'd1,    32'd0,         1'b0, BY_MODEL},
        '{ills_pkg::CMD_READ,     11'd4,    32'd0,         1'b0, BY_MODEL},
        '{ills_pkg::CMD_DELETE,   11'd5,    32'd0,         1'b1,
          '{32'd0, ills_pkg::ST_RANGE, 11'd5}},
        '{ills_pkg::CMD_DELETE,   11'd4,    32'd0,         1'b0, BY_MODEL},
        '{ills_pkg::CMD_DELETE,   11'd1,    32'd0,         1'b0, BY_MODEL},
        '{ills_pkg::CMD_DELETE,   11'd0,    32'd0,         1'b0, BY_MODEL},
        '{ills_pkg::CMD_READ,     11'd1024, 32'd0,         1'b0, BY_MODEL},
        '{ills_pkg::CMD_INS_HEAD, 11'd0,    32'hAAAA_AAAA, 1'b0, BY_MODEL},
        '{ills_pkg::CMD_INS_TAIL, 11'd0,    32'h2AAA_AAAA, 1'b0, BY_MODEL}
    };

    logic        aclk     = 1'b0;
    logic        aresetn  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [47:0] s_tdata  = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [47:0] m_tdata;

    // list contents in position order, the model's whole state
    val_bits_t    list_q [$];
    list_result_t expected_q [$];

    int n_sent       = 0;
    int n_errors     = 0;
    int n_full       = 0;
    int n_range      = 0;
    int peak_len     = 0;
    int quiet_cycles = 0;
    int n_by_cmd [8] = '{default: 0};

    indexed_linked_list_store_top u_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always #(CLK_PERIOD / 2) aclk = ~aclk;

    function automatic list_result_t apply_command(input cmd_bits_t c, input len_bits_t p,
                                                   input val_bits_t v);
        list_result_t r;
        int at;
        r = '{32'd0, ills_pkg::ST_DONE, 11'd0};
        n_by_cmd[c]++;
        case (c) inside
            ills_pkg::CMD_READ: begin
                if (p >= list_q.size()) begin
                    r.read_value = NO_ENTRY;
                    r.status     = ills_pkg::ST_RANGE;
                end else begin
                    r.read_value = list_q[p];
                end
            end
            ills_pkg::CMD_INS_HEAD, ills_pkg::CMD_INS_TAIL, ills_pkg::CMD_INS_POS: begin
                at = (c == ills_pkg::CMD_INS_HEAD) ? 0 :
                     (c == ills_pkg::CMD_INS_TAIL) ? list_q.size() : int'(p);
                // range is checked ahead of the full check
                if (at > list_q.size())
                    r.status = ills_pkg::ST_RANGE;
                else if (list_q.size() >= ills_pkg::CAPACITY)
                    r.status = ills_pkg::ST_FULL;
                else
                    list_q.insert(at, v);
            end
            ills_pkg::CMD_DELETE: begin
                if (p >= list_q.size())
                    r.status = ills_pkg::ST_RANGE;
                else
                    list_q.delete(int'(p));
            end
            default: ;
        endcase
        r.list_length = len_bits_t'(list_q.size());
        if (list_q.size() > peak_len)
            peak_len = list_q.size();
        return r;
    endfunction

    task automatic report_error(input string msg);
        n_errors++;
        if (n_errors <= 10)
            $display("ERROR at %0t ns: %s", $realtime, msg);
    endtask

    // offer one command, wait for it to be taken, then log its expected result
    task automatic send_command(input cmd_bits_t c, input len_bits_t p,
                                input val_bits_t v, input logic typed,
                                input list_result_t typed_res);
        int gap;
        list_result_t pred;
        gap = (((n_sent / 50) % 4) == 3) ? 0 : $urandom_range(0, 9);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {2'b00, v, p, c};
        do @(posedge aclk); while (!s_tready);
        pred = apply_command(c, p, v);
        if (pred.status == ills_pkg::ST_FULL)
            n_full++;
        if (pred.status == ills_pkg::ST_RANGE)
            n_range++;
        expected_q.push_back(typed ? typed_res : pred);
        n_sent++;
    endtask

    task automatic draw_command(input phase_t ph, output cmd_bits_t c,
                                output len_bits_t p, output val_bits_t v);
        int len;
        int sel;
        int ins_w;
        len = list_q.size();
        sel = $urandom_range(0, 99);
        v   = $urandom();
        p   = (len == 0) ? 11'd0 : len_bits_t'($urandom_range(0, len - 1));
        c   = ills_pkg::CMD_READ;
        case (ph)
            PH_FILL: begin
                if (sel < 85) begin
                    c = ills_pkg::CMD_INS_HEAD;
                end else if (sel < 92) begin
                    c = ills_pkg::CMD_INS_POS;
                    p = len_bits_t'($urandom_range(0, (len < 4) ? len : 4));
                end else begin
                    p = len_bits_t'($urandom_range(0, (len < 8) ? len : 8));
                end
            end
            default: begin
                ins_w = (len < 6) ? 50 : (len > 40) ? 20 : 33;
                if (sel < 6) begin
                    c = cmd_bits_t'($urandom_range(CMD_UNUSED_LO, CMD_UNUSED_HI));
                    p = len_bits_t'($urandom_range(0, 2047));
                end else if (sel < 12) begin
                    // position at or past the end
                    c = cmd_bits_t'($urandom_range(ills_pkg::CMD_READ, ills_pkg::CMD_DELETE));
                    p = len_bits_t'($urandom_range(len, 2047));
                end else if (sel < 32) begin
                    c = ills_pkg::CMD_READ;
                end else if (sel < 32 + ins_w) begin
                    c = cmd_bits_t'($urandom_range(ills_pkg::CMD_INS_HEAD,
                                                   ills_pkg::CMD_INS_POS));
                    if (c == ills_pkg::CMD_INS_POS)
                        p = len_bits_t'($urandom_range(0, len));
                end else begin
                    c = ills_pkg::CMD_DELETE;
                end
            end
        endcase
    endtask

    initial begin : stimulus
        cmd_bits_t c;
        len_bits_t p;
        val_bits_t v;
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        for (int i = 0; i < $size(DIRECTED_ROWS); i++)
            send_command(DIRECTED_ROWS[i].cmd, DIRECTED_ROWS[i].pos, DIRECTED_ROWS[i].val,
                         DIRECTED_ROWS[i].typed, DIRECTED_ROWS[i].res);

        repeat (MIX_ITEMS) begin
            draw_command(PH_MIX, c, p, v);
            send_command(c, p, v, 1'b0, BY_MODEL);
        end
        // grow a long list so later reads and deletes walk far
        repeat (FILL_ITEMS) begin
            draw_command(PH_FILL, c, p, v);
            send_command(c, p, v, 1'b0, BY_MODEL);
        end
        repeat (MIX_ITEMS) begin
            draw_command(PH_MIX, c, p, v);
            send_command(c, p, v, 1'b0, BY_MODEL);
        end
        s_tvalid <= 1'b0;

        while (expected_q.size() != 0)
            @(posedge aclk);
        repeat (TAIL_CYCLES) @(posedge aclk);

        $display("sent %0d commands: %0d reads, %0d inserts, %0d deletes, %0d unused codes",
                 n_sent, n_by_cmd[ills_pkg::CMD_READ],
                 n_by_cmd[ills_pkg::CMD_INS_HEAD] + n_by_cmd[ills_pkg::CMD_INS_TAIL]
                 + n_by_cmd[ills_pkg::CMD_INS_POS],
                 n_by_cmd[ills_pkg::CMD_DELETE],
                 n_sent - n_by_cmd[ills_pkg::CMD_READ] - n_by_cmd[ills_pkg::CMD_DELETE]
                 - n_by_cmd[ills_pkg::CMD_INS_HEAD] - n_by_cmd[ills_pkg::CMD_INS_TAIL]
                 - n_by_cmd[ills_pkg::CMD_INS_POS]);
        $display("longest list %0d entries, %0d full rejects, %0d range rejects, %0d errors",
                 peak_len, n_full, n_range, n_errors);
        if (n_errors == 0)
            $display("PASS indexed_linked_list_store_top");
        else
            $display("FAIL indexed_linked_list_store_top");
        $finish;
    end

    // result side: random hold-offs per item, one long stall to back up the input
    initial begin : result_sink
        int gap;
        int taken;
        taken = 0;
        wait (aresetn === 1'b1);
        @(posedge aclk);
        forever begin
            if (taken == PRESSURE_AT) begin
                m_tready <= 1'b0;
                repeat (PRESSURE_CYCLES) @(posedge aclk);
            end else begin
                gap = (((taken / 60) % 4) == 1) ? 0 : $urandom_range(0, 9);
                if (gap > 0) begin
                    m_tready <= 1'b0;
                    repeat (gap) @(posedge aclk);
                end
            end
            m_tready <= 1'b1;
            do @(posedge aclk); while (!m_tvalid);
            taken++;
        end
    end

    always @(posedge aclk) begin
        list_result_t got;
        list_result_t want;
        if (aresetn && m_tvalid && m_tready) begin
            got.read_value  = m_tdata[31:0];
            got.status      = ills_pkg::status_t'(m_tdata[33:32]);
            got.list_length = m_tdata[44:34];
            if (expected_q.size() == 0) begin
                report_error($sformatf("result with nothing expected: value %h status %0d len %0d",
                                       got.read_value, got.status, got.list_length));
            end else begin
                want = expected_q.pop_front();
                if (got.read_value !== want.read_value || got.status !== want.status ||
                    got.list_length !== want.list_length)
                    report_error($sformatf(
                        "expected value %h status %0d len %0d, got value %h status %0d len %0d",
                        want.read_value, want.status, want.list_length,
                        got.read_value, got.status, got.list_length));
            end
        end
    end

    // no item moving on either side for too long means the block has hung
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles == WATCHDOG_LIMIT) begin
            $display("timeout: no item moved for %0d cycles", WATCHDOG_LIMIT);
            $display("FAIL indexed_linked_list_store_top");
            $finish;
        end
    end

endmodule
